### rtl/rcf_pkg.sv
`default_nettype none

package rcf_pkg;

    // Input opcodes
    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Message types that map to dedicated chunk streams
    localparam logic [7:0] MT_AUDIO = 8'h08;
    localparam logic [7:0] MT_VIDEO = 8'h09;

    // Chunk stream ids
    localparam logic [2:0] CSID_AUDIO = 3'd7;
    localparam logic [2:0] CSID_VIDEO = 3'd6;
    localparam logic [2:0] CSID_OTHER = 3'd0;

    // Timestamp escape for the extended field
    localparam logic [31:0] EXT_TS      = 32'h00FF_FFFF;
    localparam logic [7:0]  TS_ESC_BYTE = 8'hFF;

    // Type-3 header marker
    localparam logic [7:0] FMT3_HDR = 8'hC0;

    // Chunk size after reset
    localparam logic [15:0] MAX_CHUNK_RST = 16'd128;

    // Last byte index of a type-0 header, plain and extended
    localparam logic [3:0] HDR_LAST     = 4'd11;
    localparam logic [3:0] HDR_LAST_EXT = 4'd15;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One classified item handed from front to back
    typedef struct packed {
        logic        hdr;     // 1: type-0 header, 0: payload byte
        logic        ext;     // extended timestamp present
        logic        type3;   // type-3 header precedes the payload byte
        logic        done;    // payload byte closes the message
        logic [2:0]  csid;
        logic [7:0]  mtype;
        logic [31:0] ts;
        logic [23:0] len;
        logic [31:0] sid;
        logic [7:0]  data;
    } t_job;

endpackage

`default_nettype wire

### rtl/rcf_front.sv
`default_nettype none

module rcf_front
    import rcf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_message_type,
    input  wire logic [31:0] i_timestamp,
    input  wire logic [23:0] i_message_length,
    input  wire logic [31:0] i_stream_id,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_push,
    output t_job             o_job
);

    logic [15:0] r_max_chunk;
    logic [23:0] r_byte_offset, n_byte_offset;
    logic [23:0] r_length_held, n_length_held;
    logic [15:0] r_chunk_fill,  n_chunk_fill;
    logic [2:0]  r_channel_id,  n_channel_id;
    logic [2:0]  hdr_csid;
    logic [23:0] off_inc;
    logic        in_msg;
    logic        need_t3;

    // Pick the chunk stream from the message type
    always_comb begin
        if (i_message_type == MT_AUDIO) begin
            hdr_csid = CSID_AUDIO;
        end else if (i_message_type == MT_VIDEO) begin
            hdr_csid = CSID_VIDEO;
        end else begin
            hdr_csid = CSID_OTHER;
        end
    end

    assign off_inc = r_byte_offset + 24'd1;
    assign in_msg  = r_byte_offset < r_length_held;
    assign need_t3 = (r_byte_offset != 24'd0) && (r_chunk_fill >= r_max_chunk);

    // Classify the item and advance the message state
    always_comb begin
        n_byte_offset = r_byte_offset;
        n_length_held = r_length_held;
        n_chunk_fill  = r_chunk_fill;
        n_channel_id  = r_channel_id;
        o_push        = 1'b0;
        o_job.hdr     = i_opcode == OP_HEADER;
        o_job.ext     = i_timestamp >= EXT_TS;
        o_job.type3   = need_t3;
        o_job.done    = off_inc == r_length_held;
        o_job.csid    = (i_opcode == OP_HEADER) ? hdr_csid : r_channel_id;
        o_job.mtype   = i_message_type;
        o_job.ts      = i_timestamp;
        o_job.len     = i_message_length;
        o_job.sid     = i_stream_id;
        o_job.data    = i_data_byte;
        if (i_accept) begin
            if (i_opcode == OP_HEADER) begin
                n_channel_id  = hdr_csid;
                n_length_held = i_message_length;
                n_byte_offset = 24'd0;
                n_chunk_fill  = 16'd0;
                o_push        = 1'b1;
            end else if (in_msg) begin
                // Drop bytes past the declared length; pass the rest
                n_byte_offset = off_inc;
                n_chunk_fill  = need_t3 ? 16'd1 : r_chunk_fill + 16'd1;
                o_push        = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chunk   <= MAX_CHUNK_RST;
            r_byte_offset <= '0;
            r_length_held <= '0;
            r_chunk_fill  <= '0;
            r_channel_id  <= CSID_OTHER;
        end else begin
            if (i_cfg_we) begin
                r_max_chunk <= i_cfg_data;
            end
            r_byte_offset <= n_byte_offset;
            r_length_held <= n_length_held;
            r_chunk_fill  <= n_chunk_fill;
            r_channel_id  <= n_channel_id;
        end
    end

    // The offset never runs past the declared length
    a_offset_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_offset <= r_length_held)
        else $error("byte offset beyond message length");

endmodule

`default_nettype wire

### rtl/rcf_queue.sv
`default_nettype none

module rcf_queue
    import rcf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_AW:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == Q_AW'(0) + (Q_AW+1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // A push into a full queue would lose an item
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

`default_nettype wire

### rtl/rcf_back.sv
`default_nettype none

module rcf_back
    import rcf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  wire t_job       i_q_job,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_message_done
);

    t_job        r_job;
    logic        r_busy;
    logic [3:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_done;
    logic        out_free;
    logic        emit;
    logic        is_last;
    logic [7:0]  hdr_byte;
    logic [7:0]  cur_byte;
    logic        cur_last;
    logic        cur_done;

    // Pick the type-0 header byte at the current index
    always_comb begin
        unique case (r_idx)
            4'd0:    hdr_byte = {5'd0, r_job.csid};
            4'd1:    hdr_byte = r_job.ext ? TS_ESC_BYTE : r_job.ts[23:16];
            4'd2:    hdr_byte = r_job.ext ? TS_ESC_BYTE : r_job.ts[15:8];
            4'd3:    hdr_byte = r_job.ext ? TS_ESC_BYTE : r_job.ts[7:0];
            4'd4:    hdr_byte = r_job.len[23:16];
            4'd5:    hdr_byte = r_job.len[15:8];
            4'd6:    hdr_byte = r_job.len[7:0];
            4'd7:    hdr_byte = r_job.mtype;
            4'd8:    hdr_byte = r_job.sid[7:0];
            4'd9:    hdr_byte = r_job.sid[15:8];
            4'd10:   hdr_byte = r_job.sid[23:16];
            4'd11:   hdr_byte = r_job.sid[31:24];
            4'd12:   hdr_byte = r_job.ts[31:24];
            4'd13:   hdr_byte = r_job.ts[23:16];
            4'd14:   hdr_byte = r_job.ts[15:8];
            default: hdr_byte = r_job.ts[7:0];
        endcase
    end

    // Form the current output byte and its flags
    always_comb begin
        if (r_job.hdr) begin
            is_last  = r_idx == (r_job.ext ? HDR_LAST_EXT : HDR_LAST);
            cur_byte = hdr_byte;
            cur_done = 1'b0;
        end else if (r_job.type3 && r_idx == 4'd0) begin
            is_last  = 1'b0;
            cur_byte = FMT3_HDR | {5'd0, r_job.csid};
            cur_done = 1'b0;
        end else begin
            is_last  = 1'b1;
            cur_byte = r_job.data;
            cur_done = r_job.done;
        end
        cur_last = is_last;
    end

    assign out_free = !r_out_valid || !i_stall;
    assign emit     = out_free && r_busy;
    assign o_pop    = out_free && i_q_valid && (!r_busy || is_last);

    // Step through the job and fill the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= emit;
            end
            if (emit) begin
                r_idx <= r_idx + 4'd1;
                if (is_last) begin
                    r_busy <= 1'b0;
                    r_idx  <= '0;
                end
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end
        end
    end

    // Hold payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_last <= cur_last;
            r_out_done <= cur_done;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last_of_run  = r_out_last;
    assign o_message_done = r_out_done;

    // Index stays inside a plain header
    a_hdr_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_job.hdr && !r_job.ext) |-> (r_idx <= HDR_LAST))
        else $error("header index past plain header");

    // Index stays inside a payload job
    a_pay_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_job.hdr) |-> (r_idx <= 4'd1))
        else $error("payload index out of range");

endmodule

`default_nettype wire

### rtl/rtmp_chunk_framer_top.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_valid / o_stall          i_opcode .. i_data_byte
// output    out        o_valid / i_stall          o_out_byte, o_last_of_run, o_message_done
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (bytes per chunk)
//
// A header item yields 12 or 16 bytes, a payload item one byte, or two when a
// type-3 header opens a new chunk; the back end emits one byte per cycle unless
// the output stalls. An accepted item passes the four-entry queue, which absorbs
// input while the back end serializes headers, then the job and output registers.
// Input stall rises only when that queue is full; output stall freezes the
// output register and the back end, not the front. Sync reset, chunk size 128.

module rtmp_chunk_framer_top
    import rcf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_message_type,
    input  wire logic [31:0] i_timestamp,
    input  wire logic [23:0] i_message_length,
    input  wire logic [31:0] i_stream_id,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run,
    output logic             o_message_done,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job front_job;
    t_job q_job;
    logic accept;

    assign o_stall     = q_full;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    rcf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_opcode         (i_opcode),
        .i_message_type   (i_message_type),
        .i_timestamp      (i_timestamp),
        .i_message_length (i_message_length),
        .i_stream_id      (i_stream_id),
        .i_data_byte      (i_data_byte),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_push           (q_push),
        .o_job            (front_job)
    );

    rcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    rcf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_job        (q_job),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_message_done (o_message_done)
    );

endmodule

`default_nettype wire
